// ===== src/gpc_pkg.sv =====
// Package for the GPIO port and pin controller: sizes, command and mode codes,
// per-pin configuration and the request/response transaction types.
// No dependencies; every other file of the block but gpc_ram imports it.
`default_nettype none

package gpc_pkg;

  localparam int unsigned PORT_COUNT    = 17;
  localparam int unsigned PINS_PER_PORT = 16;

  localparam int unsigned PORT_IDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int unsigned PIN_IDX_W  = (PINS_PER_PORT > 1) ? $clog2(PINS_PER_PORT) : 1;

  // Command codes.
  localparam logic [2:0] CMD_SET_OUTPUT = 3'd0;
  localparam logic [2:0] CMD_SET_INPUT  = 3'd1;
  localparam logic [2:0] CMD_WRITE      = 3'd2;
  localparam logic [2:0] CMD_TOGGLE     = 3'd3;
  localparam logic [2:0] CMD_READ       = 3'd4;
  localparam logic [2:0] CMD_GET_DIR    = 3'd5;
  localparam logic [2:0] CMD_ALTERNATE  = 3'd6;
  localparam logic [2:0] CMD_CLOCK      = 3'd7;

  // Pin mode and speed codes.
  localparam logic [1:0] MODE_INPUT  = 2'd0;
  localparam logic [1:0] MODE_OUTPUT = 2'd1;
  localparam logic [1:0] MODE_ALT    = 2'd2;
  localparam logic [1:0] SPEED_HIGH  = 2'd2;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef struct packed {
    logic [1:0] mode;
    logic       open_drain;
    logic [1:0] pull;
    logic [1:0] speed;
    logic       latch;
    logic [3:0] alt_sel;
  } pin_cfg_t;

  // One port's worth of pin settings is one memory word.
  typedef pin_cfg_t [PINS_PER_PORT-1:0] port_row_t;

  localparam int unsigned ROW_W = $bits(port_row_t);

  typedef struct packed {
    logic [2:0] cmd;
    logic [4:0] port;
    logic [4:0] pin;
    logic       level_value;
    logic [7:0] alt_function;
    logic       sampled_level;
  } gpc_req_t;

  typedef struct packed {
    logic       status;
    logic       answer;
    logic       latch_level;
    logic [1:0] pin_mode;
  } gpc_rsp_t;

  // Side information from the update logic to the state registers.
  typedef struct packed {
    logic addr_ok;
    logic clk_set;
  } upd_ctl_t;

  function automatic logic gpc_addr_ok(logic [4:0] port, logic [4:0] pin);
    logic port_ok;
    logic pin_ok;
    port_ok = ({27'd0, port} < PORT_COUNT);
    pin_ok  = ({27'd0, pin} < PINS_PER_PORT);
    return port_ok && pin_ok;
  endfunction

endpackage

`default_nettype wire

// ===== src/gpc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Read returns the old contents when the same address is written in that cycle.
`default_nettype none

module gpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/gpc_pin_update.sv =====
// Per-command update of one pin: picks the addressed pin out of a port row,
// applies the command and builds the response. Uses gpc_pkg.
`default_nettype none

module gpc_pin_update import gpc_pkg::*; (
  input  wire gpc_req_t  req_i,
  input  wire port_row_t row_i,
  output port_row_t      row_o,
  output gpc_rsp_t       rsp_o,
  output upd_ctl_t       ctl_o
);

  logic [PIN_IDX_W-1:0] pin_idx;
  pin_cfg_t             cur;
  pin_cfg_t             nxt;
  logic                 answer;
  logic                 clk_set;
  logic                 ok;

  assign pin_idx = req_i.pin[PIN_IDX_W-1:0];
  assign cur     = row_i[pin_idx];
  assign ok      = gpc_addr_ok(req_i.port, req_i.pin);

  always_comb begin
    nxt     = cur;
    answer  = 1'b0;
    clk_set = 1'b0;
    case (req_i.cmd)
      CMD_SET_OUTPUT: begin
        clk_set        = 1'b1;
        nxt.latch      = 1'b0;
        nxt.open_drain = 1'b0;
        nxt.pull       = 2'd0;
        nxt.mode       = MODE_OUTPUT;
      end
      CMD_SET_INPUT: begin
        clk_set  = 1'b1;
        nxt.mode = MODE_INPUT;
      end
      CMD_WRITE:   nxt.latch = req_i.level_value;
      CMD_TOGGLE:  nxt.latch = ~cur.latch;
      CMD_READ:    answer = req_i.sampled_level;
      CMD_GET_DIR: answer = (cur.mode == MODE_OUTPUT);
      CMD_ALTERNATE: begin
        clk_set        = 1'b1;
        nxt.alt_sel    = req_i.alt_function[3:0];
        nxt.open_drain = 1'b0;
        nxt.speed      = SPEED_HIGH;
        nxt.mode       = MODE_ALT;
      end
      default: clk_set = 1'b1;
    endcase
  end

  always_comb begin
    row_o          = row_i;
    row_o[pin_idx] = nxt;
  end

  always_comb begin
    if (ok) begin
      rsp_o = '{status: STATUS_DONE, answer: answer, latch_level: nxt.latch,
                pin_mode: nxt.mode};
    end else begin
      rsp_o = '{status: STATUS_INVALID, answer: 1'b0, latch_level: 1'b0,
                pin_mode: 2'd0};
    end
  end

  assign ctl_o = '{addr_ok: ok, clk_set: clk_set && ok};

endmodule

`default_nettype wire

// ===== src/gpio_port_pin_controller_core.sv =====
// GPIO port and pin controller, top level. A transaction accepted at one edge
// is registered into the s1 stage, and its result then into rsp_o with done_o
// high. Throughput: one command per cycle, busy stays low; the port row memory
// is read in the accept cycle and written back in the cycle after, with forwarding
// between neighbors. Reset clears the port clocks and row valid bits,
// so every pin reads as input mode with all settings zero; results cannot be stalled.
`default_nettype none

module gpio_port_pin_controller_core import gpc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire gpc_req_t req_i,
  output logic          done_o,
  output gpc_rsp_t      rsp_o
);

  logic                  accept;
  logic                  in_ok;
  logic                  s1_valid_q;
  gpc_req_t              s1_req_q;
  logic [PORT_IDX_W-1:0] s1_port;
  logic                  s1_ok;
  logic                  row_hit;
  logic                  fwd_hit;
  port_row_t             ram_rdata;
  port_row_t             row_cur;
  port_row_t             row_new;
  gpc_rsp_t              rsp_d;
  upd_ctl_t              ctl;
  logic                  wr_en;
  logic                  fwd_vld_q;
  logic [PORT_IDX_W-1:0] fwd_port_q;
  port_row_t             fwd_row_q;
  logic [PORT_COUNT-1:0] row_vld_q;
  logic [PORT_COUNT-1:0] port_clk_q;
  logic                  done_q;
  gpc_rsp_t              rsp_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign in_ok  = gpc_addr_ok(req_i.port, req_i.pin);

  gpc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (PORT_COUNT)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_port),
    .wdata_i (row_new),
    .re_i    (accept && in_ok),
    .raddr_i (req_i.port[PORT_IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign s1_port = s1_req_q.port[PORT_IDX_W-1:0];
  assign s1_ok   = gpc_addr_ok(s1_req_q.port, s1_req_q.pin);
  assign row_hit = s1_ok && row_vld_q[s1_port];
  // The row written at the last edge is not yet in the read data.
  assign fwd_hit = fwd_vld_q && (fwd_port_q == s1_port);

  always_comb begin
    if (fwd_hit) begin
      row_cur = fwd_row_q;
    end else if (row_hit) begin
      row_cur = ram_rdata;
    end else begin
      row_cur = '0;
    end
  end

  gpc_pin_update u_update (
    .req_i (s1_req_q),
    .row_i (row_cur),
    .row_o (row_new),
    .rsp_o (rsp_d),
    .ctl_o (ctl)
  );

  assign wr_en = s1_valid_q && ctl.addr_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_vld_q  <= 1'b0;
      row_vld_q  <= '0;
      port_clk_q <= '0;
      done_q     <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      fwd_vld_q  <= wr_en;
      done_q     <= s1_valid_q;
      if (wr_en) begin
        row_vld_q[s1_port] <= 1'b1;
        if (ctl.clk_set) begin
          port_clk_q[s1_port] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q <= req_i;
    end
    if (wr_en) begin
      fwd_port_q <= s1_port;
      fwd_row_q  <= row_new;
    end
    if (s1_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_o)
    else $error("result missing two cycles after accept");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == STATUS_INVALID) |->
      (!rsp_o.answer && !rsp_o.latch_level && rsp_o.pin_mode == 2'd0))
    else $error("invalid transaction returned nonzero fields");

  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.pin_mode != 2'd3))
    else $error("pin mode out of range");

  a_row_vld_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ((row_vld_q & $past(row_vld_q)) == $past(row_vld_q)))
    else $error("row valid bit cleared outside reset");

  a_clk_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && (s1_req_q.cmd == CMD_SET_OUTPUT || s1_req_q.cmd == CMD_SET_INPUT ||
               s1_req_q.cmd == CMD_ALTERNATE || s1_req_q.cmd == CMD_CLOCK))
      |=> port_clk_q[$past(s1_port)])
    else $error("port clock not enabled by configuring command");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for gpio_port_pin_controller_core: directed and random pin
// commands checked against a pin-state predictor held in a scoreboard class.
// Depends on gpc_pkg for the transaction types and the command and mode codes.
module tb_top;
  import gpc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PIN_TOTAL   = PORT_COUNT * PINS_PER_PORT;
  localparam int unsigned CYCLE_LIMIT = 40000;
  localparam int unsigned RANDOM_CMDS = 450;
  localparam int unsigned REQ_W       = $bits(gpc_req_t);

  // Keeps its own copy of every port clock and pin setting and predicts the
  // response of each accepted transaction.
  class pin_scoreboard;
    bit         port_clock_on [PORT_COUNT];
    logic [1:0] pin_mode      [PIN_TOTAL];
    bit         open_drain    [PIN_TOTAL];
    logic [1:0] pull_sel      [PIN_TOTAL];
    logic [1:0] speed_sel     [PIN_TOTAL];
    bit         out_latch     [PIN_TOTAL];
    logic [3:0] alt_sel       [PIN_TOTAL];
    gpc_rsp_t   pending_rsp   [$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned accepted;
    int unsigned bad_addr;

    function new();
      foreach (pin_mode[i]) begin
        pin_mode[i]  = MODE_INPUT;
        pull_sel[i]  = 2'd0;
        speed_sel[i] = 2'd0;
        alt_sel[i]   = 4'd0;
      end
    endfunction

    function void note_command(gpc_req_t r);
      gpc_rsp_t    e;
      int unsigned idx;
      e = '0;
      accepted++;
      if (r.port >= PORT_COUNT || r.pin >= PINS_PER_PORT) begin
        // A bad address touches nothing and answers invalid with all other fields zero.
        e.status = STATUS_INVALID;
        bad_addr++;
      end else begin
        idx = r.port * PINS_PER_PORT + r.pin;
        case (r.cmd)
          CMD_SET_OUTPUT: begin
            port_clock_on[r.port] = 1'b1;
            out_latch[idx]        = 1'b0;
            open_drain[idx]       = 1'b0;
            pull_sel[idx]         = 2'd0;
            pin_mode[idx]         = MODE_OUTPUT;
          end
          CMD_SET_INPUT: begin
            port_clock_on[r.port] = 1'b1;
            pin_mode[idx]         = MODE_INPUT;
          end
          CMD_WRITE:   out_latch[idx] = r.level_value;
          CMD_TOGGLE:  out_latch[idx] = ~out_latch[idx];
          CMD_READ:    e.answer = r.sampled_level;
          CMD_GET_DIR: e.answer = (pin_mode[idx] == MODE_OUTPUT);
          CMD_ALTERNATE: begin
            port_clock_on[r.port] = 1'b1;
            alt_sel[idx]          = r.alt_function[3:0];
            open_drain[idx]       = 1'b0;
            speed_sel[idx]        = SPEED_HIGH;
            pin_mode[idx]         = MODE_ALT;
          end
          default: port_clock_on[r.port] = 1'b1;
        endcase
        e.status      = STATUS_DONE;
        e.latch_level = out_latch[idx];
        e.pin_mode    = pin_mode[idx];
      end
      pending_rsp.push_back(e);
    endfunction

    task report_mismatch(string what, logic [1:0] got, logic [1:0] want);
      mismatches++;
      $display("%0t ns: mismatch on %s, got %0d expected %0d", $time, what, got, want);
    endtask

    task check_response(gpc_rsp_t got);
      gpc_rsp_t want;
      if (pending_rsp.size() == 0) begin
        report_mismatch("response with no command outstanding", 2'(got.pin_mode), 2'd0);
      end else begin
        want = pending_rsp.pop_front();
        checked++;
        if (got.status !== want.status)
          report_mismatch("status", 2'(got.status), 2'(want.status));
        if (got.answer !== want.answer)
          report_mismatch("answer", 2'(got.answer), 2'(want.answer));
        if (got.latch_level !== want.latch_level)
          report_mismatch("latch_level", 2'(got.latch_level), 2'(want.latch_level));
        if (got.pin_mode !== want.pin_mode)
          report_mismatch("pin_mode", got.pin_mode, want.pin_mode);
      end
    endtask
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  gpc_req_t req_i;
  logic     done_o;
  gpc_rsp_t rsp_o;

  pin_scoreboard sb;
  bit            idle_enable;
  int unsigned   cycle_count;

  gpio_port_pin_controller_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Responses are checked before the command of the same edge is noted; a result
  // passes through the s1 and output registers, so it can never belong to it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o === 1'b1)
        sb.check_response(rsp_o);
      if (start && busy === 1'b0)
        sb.note_command(req_i);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("gpio_port_pin_controller_core verification failed");
      $finish;
    end
  end

  function automatic gpc_req_t pin_cmd(logic [2:0] cmd, logic [4:0] port, logic [4:0] pin,
                                       logic level, logic [7:0] af, logic sampled);
    gpc_req_t r;
    r.cmd           = cmd;
    r.port          = port;
    r.pin           = pin;
    r.level_value   = level;
    r.alt_function  = af;
    r.sampled_level = sampled;
    return r;
  endfunction

  // Mostly valid addresses on a few hot pins so that settings pile up on them,
  // then any valid pin, then the full field range including bad addresses.
  function automatic gpc_req_t random_cmd();
    gpc_req_t    r;
    int unsigned roll;
    r    = gpc_req_t'(REQ_W'($urandom));
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      r.port = ($urandom_range(0, 1) != 0) ? 5'(PORT_COUNT - 1) : 5'($urandom_range(0, 1));
      r.pin  = 5'($urandom_range(0, 2) * 7 + $urandom_range(0, 1));
    end else if (roll < 85) begin
      r.port = 5'($urandom_range(0, PORT_COUNT - 1));
      r.pin  = 5'($urandom_range(0, PINS_PER_PORT - 1));
    end
    return r;
  endfunction

  task automatic send_cmd(gpc_req_t r);
    if (idle_enable && $urandom_range(0, 99) < 4) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  // The extra edge lets the last accepted transaction be noted before the
  // outstanding count is looked at.
  task automatic wait_all_responses();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    sb          = new();
    idle_enable = 1'b1;
    cycle_count = 0;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    req_i       <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fresh pins read as input, and an unclocked port still takes a toggle.
    send_cmd(pin_cmd(CMD_GET_DIR, 5'd0, 5'd0, 1'b0, 8'h00, 1'b0));
    send_cmd(pin_cmd(CMD_TOGGLE, 5'd3, 5'd5, 1'b0, 8'h00, 1'b0));
    send_cmd(pin_cmd(CMD_READ, 5'd3, 5'd5, 1'b0, 8'h00, 1'b1));
    send_cmd(pin_cmd(CMD_READ, 5'd3, 5'd5, 1'b1, 8'h00, 1'b0));
    send_cmd(pin_cmd(CMD_SET_OUTPUT, 5'd3, 5'd5, 1'b1, 8'hFF, 1'b1));
    send_cmd(pin_cmd(CMD_GET_DIR, 5'd3, 5'd5, 1'b0, 8'h00, 1'b0));
    send_cmd(pin_cmd(CMD_WRITE, 5'd16, 5'd15, 1'b1, 8'h00, 1'b0));
    send_cmd(pin_cmd(CMD_WRITE, 5'd16, 5'd15, 1'b0, 8'hFF, 1'b1));
    send_cmd(pin_cmd(CMD_TOGGLE, 5'd16, 5'd15, 1'b0, 8'h00, 1'b0));
    send_cmd(pin_cmd(CMD_ALTERNATE, 5'd16, 5'd15, 1'b0, 8'hFF, 1'b0));
    send_cmd(pin_cmd(CMD_GET_DIR, 5'd16, 5'd15, 1'b0, 8'h00, 1'b0));
    send_cmd(pin_cmd(CMD_TOGGLE, 5'd16, 5'd15, 1'b0, 8'h00, 1'b0));
    send_cmd(pin_cmd(CMD_SET_INPUT, 5'd16, 5'd15, 1'b0, 8'h00, 1'b0));
    send_cmd(pin_cmd(CMD_CLOCK, 5'd0, 5'd0, 1'b0, 8'h00, 1'b0));
    // Bad addresses, one just past each limit and the top of the field range.
    send_cmd(pin_cmd(CMD_CLOCK, 5'd17, 5'd0, 1'b0, 8'h00, 1'b0));
    send_cmd(pin_cmd(CMD_SET_OUTPUT, 5'd0, 5'd16, 1'b0, 8'h00, 1'b0));
    send_cmd(pin_cmd(CMD_WRITE, 5'd31, 5'd31, 1'b1, 8'hFF, 1'b1));
    send_cmd(pin_cmd(CMD_ALTERNATE, 5'd16, 5'd31, 1'b1, 8'hAA, 1'b1));
    send_cmd(pin_cmd(CMD_READ, 5'd20, 5'd3, 1'b0, 8'h00, 1'b1));
    send_cmd(pin_cmd(CMD_GET_DIR, 5'd3, 5'd5, 1'b0, 8'h00, 1'b0));
    send_cmd(pin_cmd(CMD_ALTERNATE, 5'd3, 5'd5, 1'b1, 8'h35, 1'b0));

    for (int i = 0; i < RANDOM_CMDS; i++) begin
      // One long run of back-to-back commands, and one full drain midway.
      idle_enable = !(i >= 150 && i < 300);
      if (i == 320)
        wait_all_responses();
      send_cmd(random_cmd());
    end

    wait_all_responses();
    repeat (6) @(posedge clk_i);
    while (sb.pending_rsp.size() != 0) begin
      void'(sb.pending_rsp.pop_front());
      sb.report_mismatch("response never arrived", 2'd0, 2'd0);
    end

    $display("Sent %0d pin commands over all eight command codes, %0d with a bad address.",
             sb.accepted, sb.bad_addr);
    $display("Checked %0d responses, %0d mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0)
      $display("gpio_port_pin_controller_core verification clean");
    else
      $display("gpio_port_pin_controller_core verification failed");
    $finish;
  end

endmodule
